// File: rtl/core/ir_wall_detect_averaged_assert.svh
// assertion macros for the ir wall detector
// expects signals named clock and reset in the module that uses them
`ifndef IR_WALL_DETECT_AVERAGED_ASSERT_SVH
`define IR_WALL_DETECT_AVERAGED_ASSERT_SVH

// same-cycle implication, muted during reset
`define IRWD_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, muted during reset
`define IRWD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/core/irwd_pkg.sv
// shared constants, register codes and types of the ir wall detector
// no dependencies
package irwd_pkg;

   // channel layout and field widths
   localparam int NCH       = 4;
   localparam int IN_W      = 12;
   localparam int DIFF_W    = 12;
   localparam int GAIN_W    = 12;
   localparam int VAL_W     = 14;
   localparam int PROD_W    = DIFF_W + GAIN_W;
   localparam int VAL_MAX   = (1 << VAL_W) - 1;

   // moving average window
   localparam int AVG_DEPTH = 5;
   localparam int SLOT_W    = $clog2(AVG_DEPTH);
   localparam int SUM_W     = VAL_W + $clog2(AVG_DEPTH);

   // divide by 1000 through a reciprocal multiply, exact for any PROD_W-bit product
   localparam int SCALE_DIV     = 1000;
   localparam int SCALE_SHIFT   = PROD_W + $clog2(SCALE_DIV);
   localparam int SCALE_RECIP_W = PROD_W + 1;
   localparam int SCALE_MUL_W   = PROD_W + SCALE_RECIP_W;
   localparam int QUOT_W        = SCALE_MUL_W - SCALE_SHIFT;
   localparam logic [SCALE_RECIP_W-1:0] SCALE_RECIP = SCALE_RECIP_W'(
      ((64'd1 << SCALE_SHIFT) + 64'(SCALE_DIV) - 64'd1) / 64'(SCALE_DIV));

   // divide by the window depth, same scheme
   localparam int MEAN_SHIFT   = SUM_W + $clog2(AVG_DEPTH);
   localparam int MEAN_RECIP_W = SUM_W + 1;
   localparam int MEAN_MUL_W   = SUM_W + MEAN_RECIP_W;
   localparam logic [MEAN_RECIP_W-1:0] MEAN_RECIP = MEAN_RECIP_W'(
      ((64'd1 << MEAN_SHIFT) + 64'(AVG_DEPTH) - 64'd1) / 64'(AVG_DEPTH));

   // stream payload widths
   localparam int REQ_W    = 2 * NCH * IN_W;
   localparam int RSP_BITS = NCH * VAL_W + 3;
   localparam int RSP_W    = ((RSP_BITS + 7) / 8) * 8;

   // configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = VAL_W;

   localparam logic [CSR_IDX_W-1:0] CSR_GAIN         = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_STATIC_FRONT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STATIC_SIDE  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_OK       = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_FL       = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_FR       = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_SL       = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_CAL_SR       = 3'd7;

   localparam logic [GAIN_W-1:0] GAIN_RESET       = 12'd1000;
   localparam logic [VAL_W-1:0]  STATIC_THR_RESET = 14'd200;

   // channel order: front left, front right, side left, side right
   localparam int CH_FL = 0;
   localparam int CH_FR = 1;
   localparam int CH_SL = 2;
   localparam int CH_SR = 3;

   typedef logic [NCH-1:0][VAL_W-1:0] val_vec_type;
   typedef logic [NCH-1:0][SUM_W-1:0] sum_vec_type;

   typedef struct packed {
      logic [GAIN_W-1:0] gain;
      logic [VAL_W-1:0]  static_front;
      logic [VAL_W-1:0]  static_side;
      logic              cal_ok;
      val_vec_type       cal_thr;
   } cfg_type;

endpackage

// File: rtl/core/irwd_csr.sv
// configuration registers of the ir wall detector
// depends on irwd_pkg
module irwd_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [irwd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [irwd_pkg::CSR_DATA_W-1:0] csr_data,
   output irwd_pkg::cfg_type              cfg
);
   import irwd_pkg::*;

   cfg_type cfg_ff;
   cfg_type cfg_in;

   // writes are always taken
   assign csr_ready = 1'b1;
   assign cfg       = cfg_ff;

   // register decode
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_GAIN:         cfg_in.gain          = csr_data[GAIN_W-1:0];
            CSR_STATIC_FRONT: cfg_in.static_front  = csr_data[VAL_W-1:0];
            CSR_STATIC_SIDE:  cfg_in.static_side   = csr_data[VAL_W-1:0];
            CSR_CAL_OK:       cfg_in.cal_ok        = csr_data[0];
            CSR_CAL_FL:       cfg_in.cal_thr[CH_FL] = csr_data[VAL_W-1:0];
            CSR_CAL_FR:       cfg_in.cal_thr[CH_FR] = csr_data[VAL_W-1:0];
            CSR_CAL_SL:       cfg_in.cal_thr[CH_SL] = csr_data[VAL_W-1:0];
            CSR_CAL_SR:       cfg_in.cal_thr[CH_SR] = csr_data[VAL_W-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.gain         <= GAIN_RESET;
         cfg_ff.static_front <= STATIC_THR_RESET;
         cfg_ff.static_side  <= STATIC_THR_RESET;
         cfg_ff.cal_ok       <= 1'b0;
         cfg_ff.cal_thr      <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// File: rtl/core/irwd_scale.sv
// ambient rejection and gain scaling, three register stages
// depends on irwd_pkg
module irwd_scale (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic [irwd_pkg::REQ_W-1:0]  in_data,
   input  logic [irwd_pkg::GAIN_W-1:0] gain,
   output logic                        out_valid,
   input  logic                        out_ready,
   output irwd_pkg::val_vec_type       out_val
);
   import irwd_pkg::*;

   logic [NCH-1:0][DIFF_W-1:0] diff_ff, diff_in;
   logic [NCH-1:0][PROD_W-1:0] prod_ff, prod_in;
   val_vec_type                val_ff, val_in;
   logic                       v0_ff, v1_ff, v2_ff;
   logic                       adv0, adv1, adv2;

   // stage advance chain
   assign adv2     = !v2_ff || out_ready;
   assign adv1     = !v1_ff || adv2;
   assign adv0     = !v0_ff || adv1;
   assign in_ready = adv0;

   assign out_valid = v2_ff;
   assign out_val   = val_ff;

   for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
      logic [IN_W-1:0]        off_rd, on_rd;
      logic [SCALE_MUL_W-1:0] recip_prod;
      logic [QUOT_W-1:0]      quot;

      // on minus off, clamped at zero
      assign off_rd      = in_data[ch*2*IN_W +: IN_W];
      assign on_rd       = in_data[ch*2*IN_W + IN_W +: IN_W];
      assign diff_in[ch] = (on_rd > off_rd) ? DIFF_W'(on_rd - off_rd) : '0;

      // times gain in thousandths
      assign prod_in[ch] = PROD_W'(diff_ff[ch]) * PROD_W'(gain);

      // divide by 1000 and saturate
      assign recip_prod = SCALE_MUL_W'(prod_ff[ch]) * SCALE_MUL_W'(SCALE_RECIP);
      assign quot       = recip_prod[SCALE_MUL_W-1:SCALE_SHIFT];
      assign val_in[ch] = (quot > QUOT_W'(VAL_MAX)) ? VAL_W'(VAL_MAX) : quot[VAL_W-1:0];
   end

   // valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (adv0) v0_ff <= in_valid;
         if (adv1) v1_ff <= v0_ff;
         if (adv2) v2_ff <= v1_ff;
      end
   end

   // payload stages
   always_ff @(posedge clock) begin
      if (adv0) diff_ff <= diff_in;
      if (adv1) prod_ff <= prod_in;
      if (adv2) val_ff  <= val_in;
   end

endmodule

// File: rtl/core/irwd_ring.sv
// per-channel sample rings and running window sums
// depends on irwd_pkg and the assertion macro header
`include "ir_wall_detect_averaged_assert.svh"

module irwd_ring (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  irwd_pkg::val_vec_type in_val,
   output logic                  out_valid,
   input  logic                  out_ready,
   output irwd_pkg::sum_vec_type out_sum
);
   import irwd_pkg::*;

   logic [VAL_W-1:0]  ring_ff [NCH][AVG_DEPTH];
   sum_vec_type       sum_ff, sum_in;
   logic [SLOT_W-1:0] slot_ff, slot_in;
   logic              v_ff;
   logic              adv, wr;

   assign adv       = !v_ff || out_ready;
   assign in_ready  = adv;
   assign wr        = in_valid && adv;
   assign out_valid = v_ff;
   assign out_sum   = sum_ff;

   // next write slot, wraps at the window depth
   assign slot_in = (slot_ff == SLOT_W'(AVG_DEPTH - 1)) ? '0 : slot_ff + 1'b1;

   // running sum: drop the overwritten sample, add the new one
   for (genvar ch = 0; ch < NCH; ch++) begin : g_sum
      assign sum_in[ch] = sum_ff[ch] - SUM_W'(ring_ff[ch][slot_ff]) + SUM_W'(in_val[ch]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff    <= 1'b0;
         slot_ff <= '0;
         sum_ff  <= '0;
         for (int c = 0; c < NCH; c++) begin
            for (int k = 0; k < AVG_DEPTH; k++) begin
               ring_ff[c][k] <= '0;
            end
         end
      end else begin
         if (adv) v_ff <= in_valid;
         if (wr) begin
            slot_ff <= slot_in;
            sum_ff  <= sum_in;
            for (int c = 0; c < NCH; c++) begin
               ring_ff[c][slot_ff] <= in_val[c];
            end
         end
      end
   end

   // checks
   `IRWD_ASSERT_NOW(a_slot_range, 1'b1, slot_ff <= SLOT_W'(AVG_DEPTH - 1), "ring slot out of range")
   `IRWD_ASSERT_NEXT(a_slot_hold, !wr, $stable(slot_ff) && $stable(sum_ff), "ring moved without an item")
   `IRWD_ASSERT_NEXT(a_wr_valid, wr, v_ff, "ring write did not produce a sum")
   `IRWD_ASSERT_NOW(a_sum_bound, 1'b1, sum_ff[CH_FL] <= SUM_W'(AVG_DEPTH * VAL_MAX), "window sum overflow")

endmodule

// File: rtl/core/irwd_decide.sv
// window mean, threshold selection, wall flags and the result register
// depends on irwd_pkg
module irwd_decide (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       in_valid,
   output logic                       in_ready,
   input  irwd_pkg::sum_vec_type      in_sum,
   input  irwd_pkg::cfg_type          cfg,
   output logic                       out_valid,
   input  logic                       out_ready,
   output logic [irwd_pkg::RSP_W-1:0] out_data
);
   import irwd_pkg::*;

   val_vec_type      mean;
   logic [NCH-1:0]   hit;
   logic [RSP_W-1:0] data_ff, data_in;
   logic             v_ff, adv;

   assign adv       = !v_ff || out_ready;
   assign in_ready  = adv;
   assign out_valid = v_ff;
   assign out_data  = data_ff;

   for (genvar ch = 0; ch < NCH; ch++) begin : g_ch
      logic [MEAN_MUL_W-1:0] recip_prod;
      logic [VAL_W-1:0]      thr;

      // sum divided by the window depth
      assign recip_prod = MEAN_MUL_W'(in_sum[ch]) * MEAN_MUL_W'(MEAN_RECIP);
      assign mean[ch]   = recip_prod[MEAN_SHIFT +: VAL_W];

      // calibrated threshold when valid, else the static front or side one
      if (ch == CH_FL || ch == CH_FR) begin : g_front
         assign thr = cfg.cal_ok ? cfg.cal_thr[ch] : cfg.static_front;
      end else begin : g_side
         assign thr = cfg.cal_ok ? cfg.cal_thr[ch] : cfg.static_side;
      end

      assign hit[ch] = mean[ch] > thr;
   end

   // pack: means low, then ahead, left, right
   assign data_in = RSP_W'({hit[CH_SR], hit[CH_SL], hit[CH_FL] | hit[CH_FR], mean});

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= 1'b0;
      end else if (adv) begin
         v_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) data_ff <= data_in;
   end

endmodule

// File: rtl/core/ir_wall_detect_averaged.sv
// ir wall detector: ambient rejection, gain, five-sample moving average, wall flags
// depends on irwd_pkg, irwd_csr, irwd_scale, irwd_ring and irwd_decide
//
// Usage
//   req_*: one item is a full measurement set, emitter-off and emitter-on readings
//          of the four ir channels. rsp_*: one item per request, carrying the four
//          window means and the wall ahead, left and right flags.
//   csr_*: register writes (index, data), always ready; write only while no item
//          is in flight.
// Pipeline: a result shows on rsp_tvalid once its request has passed the clamp,
//   gain multiply, divide by 1000, ring update, and mean and compare stages.
// Throughput: one item per cycle while rsp_tready stays high; each stage holds
//   one item, so up to five items are in flight.
// Reset: rings, window sums and write slot clear to zero, registers take their
//   defaults (gain 1000, static thresholds 200, calibration off).
// Stall: while rsp_tready is low the result register holds; earlier stages keep
//   taking items until every stage is full, then req_tready drops.
module ir_wall_detect_averaged (
   input  logic                           clock,
   input  logic                           reset,
   // off_front_left, on_front_left, off_front_right, on_front_right,
   // off_side_left, on_side_left, off_side_right, on_side_right (12 bit each)
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [irwd_pkg::REQ_W-1:0]      req_tdata,
   // mean_front_left, mean_front_right, mean_side_left, mean_side_right (14 bit
   // each), wall_ahead, wall_on_left, wall_on_right, zero pad
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [irwd_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [irwd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [irwd_pkg::CSR_DATA_W-1:0] csr_data
);
   import irwd_pkg::*;

   cfg_type     cfg;
   val_vec_type scaled;
   sum_vec_type sums;
   logic        scaled_valid, scaled_ready;
   logic        sum_valid, sum_ready;

   // register file
   irwd_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   // clamp and scale
   irwd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_data   (req_tdata),
      .gain      (cfg.gain),
      .out_valid (scaled_valid),
      .out_ready (scaled_ready),
      .out_val   (scaled)
   );

   // rings and running sums
   irwd_ring u_ring (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (scaled_valid),
      .in_ready  (scaled_ready),
      .in_val    (scaled),
      .out_valid (sum_valid),
      .out_ready (sum_ready),
      .out_sum   (sums)
   );

   // means and wall flags
   irwd_decide u_decide (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (sum_valid),
      .in_ready  (sum_ready),
      .in_sum    (sums),
      .cfg       (cfg),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (rsp_tdata)
   );

endmodule

// File: tb/ir_wall_detect_averaged_check.sv
// self-checking monitor for the ir wall detector: shadows the register file and the
// four averaging rings, predicts each result item and compares it with the response stream
// depends on irwd_pkg
module ir_wall_detect_averaged_check (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   input  logic                           req_tready,
   input  logic [irwd_pkg::REQ_W-1:0]      req_tdata,
   input  logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   input  logic [irwd_pkg::RSP_W-1:0]      rsp_tdata,
   input  logic                           csr_valid,
   input  logic                           csr_ready,
   input  logic [irwd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [irwd_pkg::CSR_DATA_W-1:0] csr_data,
   input  logic                           end_of_test,
   output int                             fail_count,
   output int                             pending
);
   timeunit 1ns;
   timeprecision 1ps;
   import irwd_pkg::*;

   // one result item, laid out as on rsp_tdata, members listed from the highest bit down
   typedef struct packed {
      logic        wall_on_right;
      logic        wall_on_left;
      logic        wall_ahead;
      val_vec_type mean;
   } wall_report_type;

   cfg_type          shadow_cfg;
   logic [VAL_W-1:0] ring [NCH][AVG_DEPTH];
   int unsigned      slot;
   wall_report_type  reports_due[$];
   int               results_seen;
   bit               end_done;

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      fail_count++;
   endtask

   // ambient-rejected reading scaled by gain/1000, saturated to 14 bits
   function automatic logic [VAL_W-1:0] scaled_return(input logic [IN_W-1:0] off_rd,
                                                      input logic [IN_W-1:0] on_rd);
      int unsigned diff;
      int unsigned prod;
      diff = (on_rd > off_rd) ? (on_rd - off_rd) : 0;
      prod = (diff * shadow_cfg.gain) / SCALE_DIV;
      return (prod > VAL_MAX) ? VAL_MAX[VAL_W-1:0] : prod[VAL_W-1:0];
   endfunction

   function automatic logic [VAL_W-1:0] threshold_of(input int ch);
      if (shadow_cfg.cal_ok)
         return shadow_cfg.cal_thr[ch];
      return (ch <= CH_FR) ? shadow_cfg.static_front : shadow_cfg.static_side;
   endfunction

   // write one measurement set into the rings and form means and wall flags
   function automatic wall_report_type next_report(input logic [REQ_W-1:0] set);
      wall_report_type rep;
      int unsigned     sum;
      int              c;
      int              k;
      for (c = 0; c < NCH; c++) begin
         ring[c][slot] = scaled_return(set[(2 * c) * IN_W +: IN_W],
                                       set[(2 * c + 1) * IN_W +: IN_W]);
         sum = 0;
         for (k = 0; k < AVG_DEPTH; k++)
            sum += ring[c][k];
         rep.mean[c] = VAL_W'(sum / AVG_DEPTH);
      end
      slot = (slot + 1 >= AVG_DEPTH) ? 0 : slot + 1;
      rep.wall_ahead    = (rep.mean[CH_FL] > threshold_of(CH_FL)) ||
                          (rep.mean[CH_FR] > threshold_of(CH_FR));
      rep.wall_on_left  = rep.mean[CH_SL] > threshold_of(CH_SL);
      rep.wall_on_right = rep.mean[CH_SR] > threshold_of(CH_SR);
      return rep;
   endfunction

   // register write as the block decodes it
   task automatic write_shadow(input logic [CSR_IDX_W-1:0] idx,
                               input logic [CSR_DATA_W-1:0] val);
      case (idx)
         CSR_GAIN:         shadow_cfg.gain = val[GAIN_W-1:0];
         CSR_STATIC_FRONT: shadow_cfg.static_front = val;
         CSR_STATIC_SIDE:  shadow_cfg.static_side = val;
         CSR_CAL_OK:       shadow_cfg.cal_ok = val[0];
         CSR_CAL_FL:       shadow_cfg.cal_thr[CH_FL] = val;
         CSR_CAL_FR:       shadow_cfg.cal_thr[CH_FR] = val;
         CSR_CAL_SL:       shadow_cfg.cal_thr[CH_SL] = val;
         CSR_CAL_SR:       shadow_cfg.cal_thr[CH_SR] = val;
         default: ;
      endcase
   endtask

   always @(posedge clock) begin
      wall_report_type got;
      wall_report_type want;
      int              c;
      int              k;
      if (reset) begin
         shadow_cfg.gain         = GAIN_RESET;
         shadow_cfg.static_front = STATIC_THR_RESET;
         shadow_cfg.static_side  = STATIC_THR_RESET;
         shadow_cfg.cal_ok       = 1'b0;
         shadow_cfg.cal_thr      = '0;
         for (c = 0; c < NCH; c++)
            for (k = 0; k < AVG_DEPTH; k++)
               ring[c][k] = '0;
         slot = 0;
         reports_due.delete();
         results_seen = 0;
         fail_count = 0;
         end_done = 1'b0;
      end else begin
         // result side first: a result never belongs to an item taken at the same edge
         if (rsp_tvalid && rsp_tready) begin
            got = wall_report_type'(rsp_tdata[RSP_BITS-1:0]);
            if (reports_due.size() == 0) begin
               report_mismatch($sformatf("result %0d arrived with none expected",
                                         results_seen));
            end else begin
               want = reports_due.pop_front();
               for (c = 0; c < NCH; c++)
                  if (got.mean[c] !== want.mean[c])
                     report_mismatch($sformatf("result %0d mean of channel %0d: got %0d want %0d",
                                               results_seen, c, got.mean[c], want.mean[c]));
               if (got.wall_ahead !== want.wall_ahead)
                  report_mismatch($sformatf("result %0d wall_ahead: got %b want %b",
                                            results_seen, got.wall_ahead, want.wall_ahead));
               if (got.wall_on_left !== want.wall_on_left)
                  report_mismatch($sformatf("result %0d wall_on_left: got %b want %b",
                                            results_seen, got.wall_on_left,
                                            want.wall_on_left));
               if (got.wall_on_right !== want.wall_on_right)
                  report_mismatch($sformatf("result %0d wall_on_right: got %b want %b",
                                            results_seen, got.wall_on_right,
                                            want.wall_on_right));
            end
            results_seen++;
         end
         if (csr_valid && csr_ready)
            write_shadow(csr_index, csr_data);
         if (req_tvalid && req_tready)
            reports_due.push_back(next_report(req_tdata));
         // anything still owed at the end is lost
         if (end_of_test && !end_done) begin
            end_done = 1'b1;
            if (reports_due.size() != 0)
               report_mismatch($sformatf("%0d result items never arrived",
                                         reports_due.size()));
         end
      end
      pending = reports_due.size();
   end

endmodule

// File: tb/ir_wall_detect_averaged_tb.sv
// top of the ir wall detector testbench: clock, reset, stimulus, receiver stalls and verdict
// depends on irwd_pkg, ir_wall_detect_averaged and ir_wall_detect_averaged_check
module ir_wall_detect_averaged_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import irwd_pkg::*;

   localparam int PIPE_LATENCY  = 5;
   localparam int HOLD_CYCLES   = 300;
   localparam int STALL_LIMIT   = 2000;
   localparam int IDLE_PCT      = 28;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS   = 170;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_data;
   logic                  end_of_test;
   int                    fail_count;
   int                    pending;
   bit                    calm;
   bit                    hold_ask;
   int                    quiet_cycles;

   ir_wall_detect_averaged i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   ir_wall_detect_averaged_check i_check (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .end_of_test (end_of_test),
      .fail_count  (fail_count),
      .pending     (pending)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ends the run when nothing moves on any channel for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_valid && csr_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
         $display("ir_wall_detect_averaged test failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // result receiver: random stalls, one long hold-off on request
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_ask) begin
            hold_ask = 1'b0;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // all four channels carry the same pair of readings
   function automatic logic [REQ_W-1:0] uniform_set(input logic [IN_W-1:0] off_rd,
                                                    input logic [IN_W-1:0] on_rd);
      logic [REQ_W-1:0] set;
      int               c;
      for (c = 0; c < NCH; c++) begin
         set[(2 * c) * IN_W +: IN_W]     = off_rd;
         set[(2 * c + 1) * IN_W +: IN_W] = on_rd;
      end
      return set;
   endfunction

   // one channel lit, the rest dark
   function automatic logic [REQ_W-1:0] one_channel_set(input int ch,
                                                        input logic [IN_W-1:0] off_rd,
                                                        input logic [IN_W-1:0] on_rd);
      logic [REQ_W-1:0] set;
      set = '0;
      set[(2 * ch) * IN_W +: IN_W]     = off_rd;
      set[(2 * ch + 1) * IN_W +: IN_W] = on_rd;
      return set;
   endfunction

   // mostly plausible wall echoes over ambient, plus dark, inverted and rail readings
   function automatic logic [REQ_W-1:0] random_set();
      logic [REQ_W-1:0] set;
      int               off_rd;
      int               on_rd;
      int               kind;
      int               c;
      for (c = 0; c < NCH; c++) begin
         kind = $urandom_range(9);
         if (kind <= 5) begin
            off_rd = $urandom_range(1500);
            on_rd  = off_rd + $urandom_range(2500);
         end else if (kind <= 7) begin
            off_rd = $urandom_range(4095);
            on_rd  = $urandom_range(4095);
         end else if (kind == 8) begin
            on_rd  = $urandom_range(4095);
            off_rd = on_rd + $urandom_range(4095 - on_rd);
         end else begin
            off_rd = $urandom_range(1) ? 4095 : 0;
            on_rd  = $urandom_range(1) ? 4095 : 0;
         end
         set[(2 * c) * IN_W +: IN_W]     = IN_W'(off_rd);
         set[(2 * c + 1) * IN_W +: IN_W] = IN_W'(on_rd);
      end
      return set;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_gain();
      logic [CSR_DATA_W-1:0] word;
      word = ($urandom_range(99) < 30) ? CSR_DATA_W'($urandom_range(4095)) :
                                         CSR_DATA_W'($urandom_range(500, 2000));
      // bits above the gain field are dropped by the block
      if ($urandom_range(3) == 0)
         word[CSR_DATA_W-1:GAIN_W] = '1;
      return word;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] random_threshold();
      if ($urandom_range(7) == 0)
         return CSR_DATA_W'($urandom_range(16383));
      return CSR_DATA_W'($urandom_range(2000));
   endfunction

   task automatic send_item(input logic [REQ_W-1:0] set);
      @(negedge clock);
      while (!calm && $urandom_range(99) < IDLE_PCT) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= set;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic apply_setting(input logic [CSR_DATA_W-1:0] gain,
                                input logic [CSR_DATA_W-1:0] thr_front,
                                input logic [CSR_DATA_W-1:0] thr_side,
                                input logic [CSR_DATA_W-1:0] cal_ok,
                                input logic [CSR_DATA_W-1:0] cal_fl,
                                input logic [CSR_DATA_W-1:0] cal_fr,
                                input logic [CSR_DATA_W-1:0] cal_sl,
                                input logic [CSR_DATA_W-1:0] cal_sr);
      write_reg(CSR_GAIN, gain);
      write_reg(CSR_STATIC_FRONT, thr_front);
      write_reg(CSR_STATIC_SIDE, thr_side);
      write_reg(CSR_CAL_OK, cal_ok);
      write_reg(CSR_CAL_FL, cal_fl);
      write_reg(CSR_CAL_FR, cal_fr);
      write_reg(CSR_CAL_SL, cal_sl);
      write_reg(CSR_CAL_SR, cal_sr);
   endtask

   // stop offering and let the pipeline empty
   task automatic settle();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0)
         @(negedge clock);
      repeat (PIPE_LATENCY + 3) @(negedge clock);
   endtask

   initial begin
      int p;
      int c;
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      csr_valid   = 1'b0;
      csr_index   = CSR_GAIN;
      csr_data    = '0;
      end_of_test = 1'b0;
      calm        = 1'b0;
      hold_ask    = 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: rings fill from zero, dark, inverted and equal readings
      send_item(uniform_set(12'd0, 12'd0));
      send_item(uniform_set(12'd4095, 12'd0));
      send_item(uniform_set(12'd0, 12'd4095));
      send_item(uniform_set(12'd2048, 12'd2048));
      send_item(uniform_set(12'd4095, 12'd4095));
      for (c = 0; c < NCH; c++)
         send_item(one_channel_set(c, 12'd0, 12'd4095));
      send_item(uniform_set(12'd0, 12'd4095));

      // gain past 4000 saturates the scaled value; threshold rails
      settle();
      apply_setting(14'h3fff, 14'h3fff, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0);
      repeat (5) send_item(uniform_set(12'd0, 12'd4095));
      send_item(uniform_set(12'd1, 12'd4095));

      // zero gain: every mean decays toward zero
      settle();
      apply_setting(14'd0, 14'd0, 14'h3fff, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0);
      send_item(uniform_set(12'd0, 12'd4095));
      send_item(uniform_set(12'd0, 12'd4095));
      send_item(random_set());

      // calibrated thresholds, one rail per channel
      settle();
      apply_setting(14'd1000, 14'd0, 14'd0, 14'd1, 14'd0, 14'h3fff, 14'h3fff, 14'd0);
      repeat (3) send_item(uniform_set(12'd0, 12'd4095));
      send_item(uniform_set(12'd100, 12'd50));

      // random phases, each under its own register setting
      for (p = 0; p < RANDOM_PHASES; p++) begin
         settle();
         case (p)
            1: apply_setting(14'd4000, 14'h3fff, 14'h3fff, 14'd1,
                             14'h3fff, 14'h3fff, 14'h3fff, 14'h3fff);
            3: apply_setting(14'd1, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0, 14'd0);
            default: apply_setting(random_gain(), random_threshold(), random_threshold(),
                                   CSR_DATA_W'($urandom), random_threshold(),
                                   random_threshold(), random_threshold(),
                                   random_threshold());
         endcase
         calm = (p == 0);
         if (p == 2)
            hold_ask = 1'b1;
         repeat (PHASE_ITEMS) send_item(random_set());
      end
      settle();
      calm = 1'b0;

      @(negedge clock);
      end_of_test <= 1'b1;
      @(posedge clock);
      @(negedge clock);
      if (fail_count == 0) begin
         $display("ir_wall_detect_averaged test passed");
      end else begin
         $display("ir_wall_detect_averaged test failed");
      end
      $finish;
   end

endmodule
